/* rtl/gsl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gsl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int GAIN_W     = 22;
	localparam int LEVEL_W    = 16;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 22'd65536;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd32768;
	localparam logic [16:0]        Q16_ONE     = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_GAIN     = 3'd1,
		CFG_LEVEL    = 3'd2,
		CFG_WIDE     = 3'd3,
		CFG_UNSIGNED = 3'd4,
		CFG_SWAP     = 3'd5
	} cfg_idx_t;

	// per-item sideband carried down the whole pipeline
	typedef struct packed {
		logic [15:0] raw;
		logic        last;
		logic        neg;
		logic        uni;   // gain at or below unity
		logic        lin;   // normalized level at or below knee
		logic [15:0] byp;   // unity result, or normalized level when lin
	} cm_t;

	typedef struct packed {
		cm_t         cm;
		logic        sat;
		logic [2:0]  dlo;
		logic [16:0] rem;
		logic [18:0] quo;
	} div_t;

endpackage

`default_nettype wire

/* rtl/gsl_sample_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gsl_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_in;
	logic        last_in_buffer;

	modport source (output valid, output sample_in, output last_in_buffer, input ready);
	modport sink (input valid, input sample_in, input last_in_buffer, output ready);
endinterface

interface gsl_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_out;
	logic        last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/gain_soft_limiter_top.sv */
// Throughput: one item per cycle while results.ready is high; each
// stage holds its item only while the stage after it is full and
// stalled, so bubbles close up.
// The knee division is a 19-bit restoring divider over five stages.
// Reset (arst_n low) empties the pipeline and loads register defaults;
// tanh ROM contents are fixed at elaboration.
`timescale 1ns / 1ps
`default_nettype none

module gain_soft_limiter_top
	import gsl_pkg::*;
#(
	parameter int TANH_TABLE_ENTRIES = 256
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	gsl_sample_if.sink           samples,
	gsl_result_if.source         results
);

	localparam int N   = TANH_TABLE_ENTRIES;
	localparam int IW  = $clog2(N + 1);
	localparam int NST = 14;
	localparam int DST = 5;

	typedef logic [16:0] rom_t [0:N];

	// elaboration-time long division for the ROM build
	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic rom_t build_rom();
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		longint      r;
		rom_t        t;
		term = 64'd1 << 30;
		r    = longint'(64'd1 << 30);
		e    = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = udiv(term * 64'd16, 64'(N) * 64'(k));
			if (k % 2 == 1) r = r - longint'(term);
			else r = r + longint'(term);
		end
		if (r < 0) r = 0;
		for (int k = 0; k <= N; k++) begin
			den  = (64'd1 << 30) + e;
			num  = (((64'd1 << 30) - e) << 16) + (den >> 1);
			t[k] = 17'(udiv(num, den));
			e    = (e * 64'(r) + (64'd1 << 29)) >> 30;
		end
		return t;
	endfunction

	localparam rom_t TANH_ROM = build_rom();

	// p / 32767 or p / 127 by folding the high part back in
	function automatic logic [23:0] div_full(input logic [37:0] p, input logic wide);
		logic [37:0] x;
		logic [37:0] q;
		logic [37:0] a;
		logic [37:0] b;
		logic [37:0] dv;
		x = p;
		q = '0;
		for (int i = 0; i < 6; i++) begin
			a = wide ? (x >> 15) : (x >> 7);
			b = wide ? (x & 38'h7FFF) : (x & 38'h7F);
			q = q + a;
			x = a + b;
		end
		dv = wide ? 38'd32767 : 38'd127;
		if (x >= dv) q = q + 38'd1;
		return q[23:0];
	endfunction

	// configuration
	logic                enable_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                wide_q;
	logic                ufmt_q;
	logic                swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			gain_q   <= GAIN_RESET;
			level_q  <= LEVEL_RESET;
			wide_q   <= 1'b1;
			ufmt_q   <= 1'b0;
			swap_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:   enable_q <= cfg_data[0];
				CFG_GAIN:     gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_LEVEL:    level_q  <= cfg_data[LEVEL_W-1:0];
				CFG_WIDE:     wide_q   <= cfg_data[0];
				CFG_UNSIGNED: ufmt_q   <= cfg_data[0];
				CFG_SWAP:     swap_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [16:0] room;
	logic [15:0] msb16;
	logic [15:0] mask16;
	assign room   = Q16_ONE - {1'b0, level_q};
	assign msb16  = wide_q ? 16'h8000 : 16'h0080;
	assign mask16 = wide_q ? 16'hFFFF : 16'h00FF;

	// flow control
	logic [NST:1]   vld_q;
	logic [NST+1:1] adv;

	always_comb begin
		adv[NST+1] = results.ready;
		for (int k = NST; k >= 1; k--) adv[k] = !vld_q[k] || adv[k+1];
	end

	assign samples.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= samples.valid;
			for (int k = 2; k <= NST; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: decode and gain product
	cm_t         cm1;
	logic [15:0] bits1;
	logic [16:0] mag17;
	logic [37:0] prod1;
	cm_t         cm_s1;
	logic [37:0] p_s1;

	always_comb begin
		bits1 = (wide_q && swap_q) ? {samples.sample_in[7:0], samples.sample_in[15:8]}
			: samples.sample_in;
		bits1 = bits1 & mask16;
		if (ufmt_q) bits1 = bits1 ^ msb16;
		cm1.raw  = samples.sample_in;
		cm1.last = samples.last_in_buffer;
		cm1.neg  = |(bits1 & msb16);
		cm1.uni  = gain_q <= GAIN_RESET;
		cm1.lin  = 1'b0;
		cm1.byp  = '0;
		mag17 = cm1.neg ? ((wide_q ? 17'h10000 : 17'h00100) - {1'b0, bits1}) : {1'b0, bits1};
		prod1 = {22'b0, mag17[15:0]} * {16'b0, gain_q};
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cm_s1 <= cm1;
			p_s1  <= prod1;
		end
	end

	// stage 2: unity result, or level normalized to full scale
	cm_t         cm2;
	logic [23:0] v2;
	cm_t         cm_s2;
	logic [23:0] v_s2;

	always_comb begin
		cm2 = cm_s1;
		if (cm_s1.uni) cm2.byp = p_s1[31:16];
		if (cm_s1.neg) v2 = wide_q ? 24'(p_s1 >> 15) : 24'(p_s1 >> 7);
		else v2 = div_full(p_s1, wide_q);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cm_s2 <= cm2;
			v_s2  <= v2;
		end
	end

	// stage 3: knee test and divider setup
	div_t        div_s [0:DST];
	div_t        dv3;
	logic [23:0] d3;

	always_comb begin
		dv3.cm  = cm_s2;
		dv3.cm.lin = v_s2 <= {8'b0, level_q};
		d3      = v_s2 - {8'b0, level_q};
		dv3.sat = d3 >= {4'b0, room, 3'b0};
		dv3.rem = d3[19:3];
		dv3.dlo = d3[2:0];
		dv3.quo = '0;
		if (!cm_s2.uni && dv3.cm.lin) dv3.cm.byp = v_s2[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv[3]) div_s[0] <= dv3;
	end

	// stages 4-8: (v - lev) * 65536 / room, four quotient bits a stage (three in the last)
	for (genvar g = 0; g < DST; g++) begin : g_div
		localparam int J0 = 18 - 4 * g;
		div_t        nx;
		logic [17:0] r2;
		int          j;

		always_comb begin
			nx = div_s[g];
			r2 = '0;
			j  = 0;
			for (int i = 0; i < 4; i++) begin
				j = J0 - i;
				if (j >= 0) begin
					r2 = {nx.rem, (j >= 16) ? div_s[g].dlo[j-16] : 1'b0};
					if (r2 >= {1'b0, room}) begin
						nx.rem    = 17'(r2 - {1'b0, room});
						nx.quo[j] = 1'b1;
					end else begin
						nx.rem = r2[16:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[4+g]) div_s[g+1] <= nx;
		end
	end

	// stage 9: ROM position
	logic [31:0]   pw9;
	cm_t           cm_s9;
	logic [IW-1:0] idx_s9;
	logic [15:0]   frac_s9;

	assign pw9 = 32'(div_s[DST].quo) * 32'(N);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			cm_s9   <= div_s[DST].cm;
			idx_s9  <= div_s[DST].sat ? IW'(N) : pw9[19 +: IW];
			frac_s9 <= div_s[DST].sat ? 16'h0 : pw9[18:3];
		end
	end

	// stage 10: ROM read of both neighbors
	logic [IW-1:0] idx_nx;
	cm_t           cm_s10;
	logic [16:0]   t0_s10;
	logic [16:0]   t1_s10;
	logic [15:0]   frac_s10;

	assign idx_nx = (idx_s9 == IW'(N)) ? idx_s9 : idx_s9 + IW'(1);

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			cm_s10   <= cm_s9;
			t0_s10   <= TANH_ROM[idx_s9];
			t1_s10   <= TANH_ROM[idx_nx];
			frac_s10 <= frac_s9;
		end
	end

	// stage 11: interpolation
	logic [32:0] ip11;
	cm_t         cm_s11;
	logic [16:0] t_s11;

	assign ip11 = {16'b0, 17'(t1_s10 - t0_s10)} * {17'b0, frac_s10};

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			cm_s11 <= cm_s10;
			t_s11  <= (t1_s10 < t0_s10) ? t0_s10 : 17'(t0_s10 + ip11[32:16]);
		end
	end

	// stage 12: limited level
	logic [33:0] mt12;
	cm_t         cm_s12;
	logic [16:0] l_s12;

	assign mt12 = {17'b0, t_s11} * {17'b0, room};

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			cm_s12 <= cm_s11;
			l_s12  <= cm_s11.lin ? {1'b0, cm_s11.byp} : 17'({1'b0, level_q} + mt12[32:16]);
		end
	end

	// stage 13: back to full scale with rounding
	logic [15:0] full13;
	logic [33:0] sc13;
	cm_t         cm_s13;
	logic [15:0] om_s13;

	always_comb begin
		full13 = cm_s12.neg ? msb16 : msb16 - 16'd1;
		sc13   = {18'b0, full13} * {17'b0, l_s12}
			+ (cm_s12.neg ? 34'd32767 : 34'd32768);
	end

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			cm_s13 <= cm_s12;
			om_s13 <= cm_s12.uni ? cm_s12.byp : sc13[31:16];
		end
	end

	// stage 14: encode into the sample format, or pass the raw sample when disabled
	logic [15:0] enc14;
	logic [15:0] smp_s14;
	logic        last_s14;

	always_comb begin
		enc14 = cm_s13.neg ? (16'h0 - om_s13) : om_s13;
		enc14 = enc14 & mask16;
		if (ufmt_q) enc14 = enc14 ^ msb16;
		if (wide_q && swap_q) enc14 = {enc14[7:0], enc14[15:8]};
		if (!enable_q) enc14 = cm_s13.raw;
	end

	always_ff @(posedge clk) begin
		if (adv[14]) begin
			smp_s14  <= enc14;
			last_s14 <= cm_s13.last;
		end
	end

	assign results.valid      = vld_q[NST];
	assign results.sample_out = smp_s14;
	assign results.last_out   = last_s14;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import gsl_pkg::*;

	localparam int TANH_N     = 256;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 80;
	localparam int DRAIN_WAIT = 20;

	typedef struct packed {
		bit          en;
		bit [21:0]   gain;
		bit [15:0]   lev;
		bit          wide;
		bit          uns;
		bit          swap;
	} gain_cfg_t;

	typedef struct {
		bit [15:0] smp;
		bit        last;
	} sample_item_t;

	typedef struct {
		gain_cfg_t cfg;
		bit [15:0] smp;
		bit        last;
		bit        known;
		bit [15:0] want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gsl_sample_if smp_ch();
	gsl_result_if res_ch();

	gain_soft_limiter_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .samples(smp_ch), .results(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gain_cfg_t cur;
	bit [31:0] tanh_rom [0:TANH_N];
	sample_item_t pending_out[$];
	int errors = 0, n_in = 0, n_out = 0, n_phase = 0, idle_cycles = 0;
	bit hold_req = 0;
	bit [31:0] n_limited = 0;

	function automatic void build_tanh();
		longint unsigned term, e, den, num;
		longint r;
		term = 64'd1 << 30;
		r = 64'sd1 << 30;
		e = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = (term * 16) / (TANH_N * k);
			if (k % 2) r -= longint'(term);
			else r += longint'(term);
		end
		if (r < 0) r = 0;
		for (int k = 0; k <= TANH_N; k++) begin
			den = (64'd1 << 30) + e;
			num = (((64'd1 << 30) - e) << 16) + den / 2;
			tanh_rom[k] = 32'(num / den);
			e = (e * longint'(r) + (64'd1 << 29)) >> 30;
		end
	endfunction

	function automatic longint unsigned tanh_interp(longint unsigned u);
		longint unsigned pos, idx, frac, t0, t1;
		if (u >= (64'd8 << 16)) return tanh_rom[TANH_N];
		pos = (u * TANH_N) >> 3;
		idx = pos >> 16;
		frac = pos & 64'hFFFF;
		if (idx >= TANH_N) return tanh_rom[TANH_N];
		t0 = tanh_rom[idx];
		t1 = tanh_rom[idx + 1];
		if (t1 < t0) return t0;
		return t0 + (((t1 - t0) * frac) >> 16);
	endfunction

	function automatic longint unsigned knee_compress(longint unsigned v);
		longint unsigned lev, room, u;
		lev = cur.lev;
		room = 65536 - lev;
		if (v <= lev) return v;
		u = ((v - lev) << 16) / room;
		if (u > (64'd8 << 16)) u = 64'd8 << 16;
		return lev + ((tanh_interp(u) * room) >> 16);
	endfunction

	function automatic bit [15:0] scaled_sample(bit [15:0] raw);
		bit [15:0] mask, msb, bits;
		longint unsigned mag, full, lim, outmag;
		bit neg;
		if (!cur.en) return raw;
		mask = cur.wide ? 16'hFFFF : 16'h00FF;
		msb = cur.wide ? 16'h8000 : 16'h0080;
		bits = raw;
		if (cur.wide && cur.swap) bits = {bits[7:0], bits[15:8]};
		bits &= mask;
		if (cur.uns) bits ^= msb;
		neg = (bits & msb) != 0;
		mag = neg ? (longint'(mask) + 1 - bits) : bits;
		if (cur.gain <= 65536) begin
			outmag = (mag * cur.gain) >> 16;
		end else begin
			full = neg ? msb : msb - 1;
			lim = knee_compress((mag * cur.gain) / full);
			if (lim > cur.lev) n_limited++;
			outmag = (full * lim + (neg ? 32767 : 32768)) >> 16;
		end
		bits = neg ? (16'(-outmag) & mask) : (16'(outmag) & mask);
		if (cur.uns) bits ^= msb;
		if (cur.wide && cur.swap) bits = {bits[7:0], bits[15:8]};
		return bits;
	endfunction

	task automatic wait_drained();
		smp_ch.valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_cfg(gain_cfg_t c);
		wait_drained();
		write_reg(CFG_ENABLE, CFG_DATA_W'(c.en));
		write_reg(CFG_GAIN, c.gain);
		write_reg(CFG_LEVEL, CFG_DATA_W'(c.lev));
		write_reg(CFG_WIDE, CFG_DATA_W'(c.wide));
		write_reg(CFG_UNSIGNED, CFG_DATA_W'(c.uns));
		write_reg(CFG_SWAP, CFG_DATA_W'(c.swap));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur = c;
		n_phase++;
	endtask

	// drive one item, return once accepted; expectation is queued at the accepting edge
	task automatic send_sample(bit [15:0] s, bit l, bit known, bit [15:0] want);
		int gap;
		sample_item_t exp_item;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.sample_in <= s;
		smp_ch.last_in_buffer <= l;
		@(posedge clk iff smp_ch.ready);
		exp_item.smp = scaled_sample(s);
		exp_item.last = l;
		if (known && exp_item.smp !== want) begin
			errors++;
			if (errors <= 10)
				$display("table row mismatch: sample %h predicted %h listed %h",
					s, exp_item.smp, want);
		end
		pending_out.push_back(exp_item);
		n_in++;
	endtask

	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		sample_item_t e;
		if (res_ch.valid && res_ch.ready) begin
			n_out++;
			if (pending_out.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item: %h", res_ch.sample_out);
			end else begin
				e = pending_out.pop_front();
				if (res_ch.sample_out !== e.smp || res_ch.last_out !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: sample exp %h got %h, last exp %b got %b",
							e.smp, res_ch.sample_out, e.last, res_ch.last_out);
				end
			end
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int w;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 3);
			if ($urandom_range(0, 2) == 0) w = 0;
			if (hold_req) begin
				w = HOLD_LEN;
				hold_req = 0;
			end
			if (w > 0) begin
				res_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk iff (res_ch.valid && res_ch.ready));
		end
	end

	row_t rows[$];

	function automatic gain_cfg_t mk(bit en, bit [21:0] g, bit [15:0] lv, bit wd, bit un,
		bit sw);
		gain_cfg_t c;
		c.en = en; c.gain = g; c.lev = lv; c.wide = wd; c.uns = un; c.swap = sw;
		return c;
	endfunction

	function automatic row_t mkrow(gain_cfg_t c, bit [15:0] s, bit l, bit k, bit [15:0] w);
		row_t r;
		r.cfg = c; r.smp = s; r.last = l; r.known = k; r.want = w;
		return r;
	endfunction

	function automatic bit [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0080;
			3: return 16'h007F;
			4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic bit [21:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 22'd0;
			1: return 22'd65536;
			2: return 22'd65537;
			3: return 22'h3FFFFF;
			4: return 22'($urandom_range(0, 65536));
			5: return 22'($urandom_range(65537, 4 * 65536));
			default: return 22'($urandom());
		endcase
	endfunction

	function automatic bit [15:0] rand_level();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		gain_cfg_t c;
		smp_ch.valid = 1'b0;
		smp_ch.sample_in = '0;
		smp_ch.last_in_buffer = 1'b0;
		build_tanh();
		cur = mk(0, 22'd65536, 16'd32768, 1, 0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: pass-through
		rows.push_back(mkrow(cur, 16'h0000, 0, 1, 16'h0000));
		rows.push_back(mkrow(cur, 16'hFFFF, 1, 1, 16'hFFFF));
		rows.push_back(mkrow(cur, 16'h8000, 0, 1, 16'h8000));
		c = mk(1, 22'd65536, 16'd32768, 1, 0, 0);
		rows.push_back(mkrow(c, 16'h7FFF, 0, 1, 16'h7FFF));
		rows.push_back(mkrow(c, 16'h8000, 1, 1, 16'h8000));
		c = mk(1, 22'd0, 16'd32768, 1, 0, 0);
		rows.push_back(mkrow(c, 16'h8000, 0, 1, 16'h0000));
		rows.push_back(mkrow(c, 16'h7FFF, 0, 1, 16'h0000));
		c = mk(1, 22'd0, 16'd32768, 1, 1, 0);
		rows.push_back(mkrow(c, 16'h1234, 0, 1, 16'h8000));
		// 8-bit: high byte cleared, swap ignored
		c = mk(1, 22'd0, 16'd32768, 0, 1, 1);
		rows.push_back(mkrow(c, 16'hFF12, 1, 1, 16'h0080));
		c = mk(1, 22'd65536, 16'd32768, 0, 0, 1);
		rows.push_back(mkrow(c, 16'hAB80, 0, 1, 16'h0080));
		rows.push_back(mkrow(c, 16'hCD7F, 0, 1, 16'h007F));
		c = mk(1, 22'd65536, 16'd32768, 1, 0, 1);
		rows.push_back(mkrow(c, 16'h0080, 0, 1, 16'h0080));
		// max gain drives the knee far past the end of the table
		c = mk(1, 22'h3FFFFF, 16'd0, 1, 0, 0);
		rows.push_back(mkrow(c, 16'h7FFF, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h8000, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h0001, 1, 0, 0));
		c = mk(1, 22'd65537, 16'hFFFF, 1, 0, 0);
		rows.push_back(mkrow(c, 16'h7FFF, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h8001, 0, 0, 0));
		c = mk(1, 22'd131072, 16'd32768, 0, 1, 0);
		rows.push_back(mkrow(c, 16'h00FF, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h0000, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h00C0, 1, 0, 0));
		c = mk(1, 22'd200000, 16'd20000, 1, 1, 1);
		rows.push_back(mkrow(c, 16'h00FF, 0, 0, 0));
		rows.push_back(mkrow(c, 16'hFF7F, 0, 0, 0));
		rows.push_back(mkrow(c, 16'h3412, 1, 0, 0));

		foreach (rows[i]) begin
			if (i > 2 && rows[i].cfg != cur) apply_cfg(rows[i].cfg);
			send_sample(rows[i].smp, rows[i].last, rows[i].known, rows[i].want);
		end

		for (int p = 0; p < 16; p++) begin
			c = mk($urandom_range(0, 9) != 0, rand_gain(), rand_level(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			if (p == 0) c = mk(1, 22'h3FFFFF, 16'hFFFF, 1, 1, 1);
			if (p == 1) c = mk(1, 22'd300000, 16'd0, 0, 0, 0);
			apply_cfg(c);
			for (int j = 0; j < 115; j++) begin
				if (p == 4 && j == 20) hold_req = 1;
				if (p == 8 && j == 60) wait_drained();
				send_sample(rand_sample(), $urandom_range(0, 7) == 0, 0, 0);
			end
		end
		wait_drained();

		$display("covered %0d items over %0d register settings, %0d past the knee",
			n_in, n_phase, n_limited);
		$display("incl. long output hold-off and input pause; %0d mismatches", errors);
		if (errors == 0 && pending_out.size() == 0 && n_out == n_in)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* gain_soft_limiter_top.f */
rtl/gsl_pkg.sv
rtl/gsl_sample_if.sv
rtl/gain_soft_limiter_top.sv
dv/tb.sv
